>>> src/bihm_pkg.sv
// shared constants, codes and control types of the id/handle store
`default_nettype none

package bihm_pkg;

  // store size and derived widths
  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned SLOT_W      = 2 * WORD_W;

  // request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD       = 3'd0,
    CMD_RM_ID     = 3'd1,
    CMD_RM_HANDLE = 3'd2,
    CMD_LK_ID     = 3'd3,
    CMD_LK_HANDLE = 3'd4
  } cmd_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture the incoming request
    logic scan_clr;  // restart the slot scan
    logic step;      // read the next slot
    logic apply;     // update the store and load the result register
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;   // match seen, last slot compared, or nothing to search
    logic issued_all;  // every slot has been read
    logic out_free;    // result register can take a new result
  } dp_sts_t;

endpackage

`default_nettype wire

>>> src/bihm_if.sv
// request and result channel interfaces
`default_nettype none

interface bihm_req_if;
  logic                                valid;
  logic                                ready;
  logic [bihm_pkg::CMD_W-1:0]          cmd;
  logic signed [bihm_pkg::WORD_W-1:0]  key_id;
  logic [bihm_pkg::WORD_W-1:0]         handle;
  logic signed [bihm_pkg::WORD_W-1:0]  default_id;

  modport source (output valid, cmd, key_id, handle, default_id, input ready);
  modport sink   (input valid, cmd, key_id, handle, default_id, output ready);
endinterface

interface bihm_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  found;
  logic                                  full_res;
  logic signed [bihm_pkg::WORD_W-1:0]    result_id;
  logic [bihm_pkg::WORD_W-1:0]           result_handle;
  logic [bihm_pkg::COUNT_OUT_W-1:0]      entry_count;

  modport source (output valid, found, full_res, result_id, result_handle, entry_count,
                  input ready);
  modport sink   (input valid, found, full_res, result_id, result_handle, entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> src/bihm_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module bihm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/bihm_ctrl.sv
// controller state machine for the id/handle store
`default_nettype none

module bihm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bihm_pkg::dp_sts_t  sts,
  output bihm_pkg::ctl_cmd_t      ctl
);

  bihm_pkg::state_t state_r;
  bihm_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bihm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bihm_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bihm_pkg::ST_SCAN;
        end
      end
      bihm_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = bihm_pkg::ST_DONE;
        end
      end
      bihm_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = bihm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bihm_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    ctl.load     = 1'b0;
    ctl.scan_clr = 1'b0;
    ctl.step     = 1'b0;
    ctl.apply    = 1'b0;
    case (state_r)
      bihm_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        ctl.load     = in_valid;
        ctl.scan_clr = in_valid;
      end
      bihm_pkg::ST_SCAN: begin
        ctl.step = !sts.scan_done && !sts.issued_all;
      end
      bihm_pkg::ST_DONE: begin
        ctl.apply = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/bihm_dp.sv
// datapath: request registers, slot store, scan and result register
`default_nettype none

module bihm_dp (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic [bihm_pkg::CMD_W-1:0]               in_cmd,
  input  wire logic signed [bihm_pkg::WORD_W-1:0]       in_key_id,
  input  wire logic [bihm_pkg::WORD_W-1:0]              in_handle,
  input  wire logic signed [bihm_pkg::WORD_W-1:0]       in_default_id,
  input  wire logic                                     out_ready,
  input  wire bihm_pkg::ctl_cmd_t                       ctl,
  output bihm_pkg::dp_sts_t                             sts,
  output logic                                          out_valid,
  output logic                                          out_found,
  output logic                                          out_full_res,
  output logic signed [bihm_pkg::WORD_W-1:0]            out_result_id,
  output logic [bihm_pkg::WORD_W-1:0]                   out_result_handle,
  output logic [bihm_pkg::COUNT_OUT_W-1:0]              out_entry_count
);

  localparam logic [bihm_pkg::IDX_W-1:0] LAST_IDX = bihm_pkg::IDX_W'(bihm_pkg::CAPACITY - 1);

  // request registers
  logic [bihm_pkg::CMD_W-1:0]  cmd_r;
  logic [bihm_pkg::WORD_W-1:0] key_r;
  logic [bihm_pkg::WORD_W-1:0] handle_r;
  logic [bihm_pkg::WORD_W-1:0] dflt_r;

  // store state
  logic [bihm_pkg::CAPACITY-1:0] valid_r;
  logic [bihm_pkg::CAPACITY-1:0] valid_nxt;
  logic [bihm_pkg::CNT_W-1:0]    count_r;
  logic [bihm_pkg::CNT_W-1:0]    count_nxt;

  // scan state
  logic [bihm_pkg::IDX_W-1:0]  rd_idx_r;
  logic [bihm_pkg::IDX_W-1:0]  cmp_idx_r;
  logic                        cmp_vld_r;
  logic                        issued_all_r;
  logic                        hit_r;
  logic [bihm_pkg::IDX_W-1:0]  hit_idx_r;
  logic [bihm_pkg::WORD_W-1:0] hit_id_r;
  logic [bihm_pkg::WORD_W-1:0] hit_h_r;
  logic                        free_ok_r;
  logic [bihm_pkg::IDX_W-1:0]  free_idx_r;

  // result register
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        found_r;
  logic                        full_r;
  logic [bihm_pkg::WORD_W-1:0] rid_r;
  logic [bihm_pkg::WORD_W-1:0] rh_r;
  logic [bihm_pkg::COUNT_OUT_W-1:0] ecount_r;

  // slot ram signals
  logic                        we;
  logic [bihm_pkg::IDX_W-1:0]  waddr;
  logic [bihm_pkg::SLOT_W-1:0] wdata;
  logic [bihm_pkg::SLOT_W-1:0] rdata;
  logic [bihm_pkg::WORD_W-1:0] rd_id;
  logic [bihm_pkg::WORD_W-1:0] rd_h;

  // request decode and compare
  logic is_search;
  logic by_handle;
  logic match_now;
  logic last_cmp;

  // result next values
  logic                        res_found;
  logic                        res_full;
  logic [bihm_pkg::WORD_W-1:0] res_id;
  logic [bihm_pkg::WORD_W-1:0] res_h;

  bihm_ram #(
    .WIDTH (bihm_pkg::SLOT_W),
    .DEPTH (bihm_pkg::CAPACITY)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.step),
    .raddr (rd_idx_r),
    .rdata (rdata)
  );

  assign rd_id = rdata[bihm_pkg::SLOT_W-1:bihm_pkg::WORD_W];
  assign rd_h  = rdata[bihm_pkg::WORD_W-1:0];

  // command decode
  assign is_search = cmd_r inside {bihm_pkg::CMD_ADD, bihm_pkg::CMD_RM_ID,
                                   bihm_pkg::CMD_RM_HANDLE, bihm_pkg::CMD_LK_ID,
                                   bihm_pkg::CMD_LK_HANDLE};
  assign by_handle = cmd_r inside {bihm_pkg::CMD_RM_HANDLE, bihm_pkg::CMD_LK_HANDLE};

  // compare the slot read last cycle
  assign match_now = cmp_vld_r && valid_r[cmp_idx_r] &&
                     (by_handle ? (rd_h == handle_r) : (rd_id == key_r));
  assign last_cmp  = cmp_vld_r && (cmp_idx_r == LAST_IDX);

  // status to controller
  assign sts.scan_done  = !is_search || match_now || last_cmp;
  assign sts.issued_all = issued_all_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= in_cmd;
      key_r    <= in_key_id;
      handle_r <= in_handle;
      dflt_r   <= in_default_id;
    end
  end

  // scan counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r     <= '0;
      cmp_vld_r    <= 1'b0;
      issued_all_r <= 1'b0;
      hit_r        <= 1'b0;
      free_ok_r    <= 1'b0;
    end else if (ctl.scan_clr) begin
      rd_idx_r     <= '0;
      cmp_vld_r    <= 1'b0;
      issued_all_r <= 1'b0;
      hit_r        <= 1'b0;
      free_ok_r    <= 1'b0;
    end else begin
      cmp_vld_r <= ctl.step;
      if (ctl.step) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        if (rd_idx_r == LAST_IDX) begin
          issued_all_r <= 1'b1;
        end
      end
      if (match_now) begin
        hit_r <= 1'b1;
      end
      if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_ok_r) begin
        free_ok_r <= 1'b1;
      end
    end
  end

  // scan payload: compared index, hit pair, first free slot
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      cmp_idx_r <= rd_idx_r;
    end
    if (match_now) begin
      hit_idx_r <= cmp_idx_r;
      hit_id_r  <= rd_id;
      hit_h_r   <= rd_h;
    end
    if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_ok_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  // store update and result at apply time
  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    we        = 1'b0;
    waddr     = hit_idx_r;
    wdata     = {key_r, handle_r};
    res_found = 1'b0;
    res_full  = 1'b0;
    res_id    = '0;
    res_h     = '0;
    case (cmd_r)
      bihm_pkg::CMD_ADD: begin
        if (hit_r) begin
          we        = ctl.apply;
          res_found = 1'b1;
          res_id    = key_r;
          res_h     = handle_r;
        end else if (free_ok_r) begin
          we    = ctl.apply;
          waddr = free_idx_r;
          valid_nxt[free_idx_r] = 1'b1;
          count_nxt = count_r + bihm_pkg::CNT_W'(1);
        end else begin
          res_full = 1'b1;
        end
      end
      bihm_pkg::CMD_RM_ID, bihm_pkg::CMD_RM_HANDLE: begin
        if (hit_r) begin
          res_found = 1'b1;
          res_id    = hit_id_r;
          res_h     = hit_h_r;
          valid_nxt[hit_idx_r] = 1'b0;
          count_nxt = count_r - bihm_pkg::CNT_W'(1);
        end
      end
      bihm_pkg::CMD_LK_ID: begin
        if (hit_r) begin
          res_found = 1'b1;
          res_id    = hit_id_r;
          res_h     = hit_h_r;
        end
      end
      bihm_pkg::CMD_LK_HANDLE: begin
        if (hit_r) begin
          res_found = 1'b1;
          res_id    = hit_id_r;
          res_h     = hit_h_r;
        end else begin
          res_id = dflt_r;
        end
      end
      default: begin
        res_found = 1'b0;
      end
    endcase
  end

  // valid bits and entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (ctl.apply) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      found_r  <= res_found;
      full_r   <= res_full;
      rid_r    <= res_id;
      rh_r     <= res_h;
      ecount_r <= bihm_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = found_r;
  assign out_full_res      = full_r;
  assign out_result_id     = rid_r;
  assign out_result_handle = rh_r;
  assign out_entry_count   = ecount_r;

endmodule

`default_nettype wire

>>> src/bidirectional_id_handle_map.sv
// top level of the bidirectional id/handle store
`default_nettype none

// Store of up to 64 unique id/handle pairs held in a single slot RAM with one
// read and one write port; every request with a used command code scans the
// slots one per cycle through the read port, stopping at the first match. A
// request that matches nothing, and any add of a new id, scans all slots;
// unused command codes skip the scan. A new request is taken only once the
// result of the last one has been loaded into the result register. Valid bits
// live in flip-flops and are cleared by reset, so the store is empty at once
// with no clearing pass. The result register lets a new request be taken while
// a result still waits.
module bidirectional_id_handle_map (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bihm_req_if.sink    in_req,
  bihm_rsp_if.source  out_rsp
);

  bihm_pkg::ctl_cmd_t ctl;
  bihm_pkg::dp_sts_t  sts;

  bihm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bihm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_req.cmd),
    .in_key_id         (in_req.key_id),
    .in_handle         (in_req.handle),
    .in_default_id     (in_req.default_id),
    .out_ready         (out_rsp.ready),
    .ctl               (ctl),
    .sts               (sts),
    .out_valid         (out_rsp.valid),
    .out_found         (out_rsp.found),
    .out_full_res      (out_rsp.full_res),
    .out_result_id     (out_rsp.result_id),
    .out_result_handle (out_rsp.result_handle),
    .out_entry_count   (out_rsp.entry_count)
  );

`ifndef NO_ASSERTIONS
  // a new result only appears after the store was updated
  a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_rsp.valid) |-> $past(ctl.apply))
    else $error("result valid rose without an apply");

  // a waiting result is never overwritten
  a_apply_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.apply |-> sts.out_free)
    else $error("apply while result register is occupied");

  // the scan never reads past the last slot
  a_no_overscan: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> !sts.issued_all)
    else $error("slot read after the whole store was scanned");

  // a refused add never reports a match
  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> !(out_rsp.found && out_rsp.full_res))
    else $error("result flags both found and full");
`endif

endmodule

`default_nettype wire
